// ===== rtl/core/gte_pkg.sv =====
// shared types and constants for the graph traversal engine
`timescale 1ns / 1ps
package gte_pkg;

  localparam int unsigned VTX_W = 6;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned STS_W = 2;
  localparam int unsigned NV_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 2'd0,
    ACT_BFS     = 2'd1,
    ACT_DFS_REC = 2'd2,
    ACT_DFS_STK = 2'd3
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_VISIT    = 2'd0,
    STS_REJECT   = 2'd1,
    STS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_ADD_WR,
    S_B_POP,
    S_B_VTX,
    S_B_HEAD,
    S_B_EDGE,
    S_K_POP,
    S_K_VTX,
    S_K_HEAD,
    S_K_EDGE,
    S_R_LOAD,
    S_R_STEP,
    S_R_POP,
    S_R_EDGE,
    S_FIN
  } state_e;

  // vertex source for list reads and visited updates
  typedef enum logic [1:0] {
    VS_FROM,
    VS_WL,
    VS_TGT
  } vsel_e;

  typedef enum logic [1:0] {
    ES_HEAD,
    ES_NEXT,
    ES_TOP
  } esel_e;

  typedef enum logic [2:0] {
    RS_FROM,
    RS_WL,
    RS_TGT,
    RS_REJ,
    RS_OVF
  } rsel_e;

  typedef struct packed {
    logic    cap_in;
    logic    list_rd;
    vsel_e   list_sel;
    logic    add_wr;
    logic    vis_clr;
    logic    vis_set;
    vsel_e   vis_sel;
    logic    wl_init;
    logic    wl_pop_q;
    logic    wl_pop_s;
    logic    wl_push;
    logic    edge_rd;
    esel_e   edge_sel;
    logic    produce;
    rsel_e   res_sel;
    logic    finish;
    logic    depth_clr;
    logic    top_load;
    logic    top_adv;
    logic    fr_push;
    logic    fr_pop_rd;
    logic    fr_pop;
  } dp_cmd_t;

  typedef struct packed {
    action_e act;
    logic    bad_add;
    logic    bad_src;
    logic    full;
    logic    nonempty;
    logic    e_last;
    logic    vis_tgt;
    logic    vis_wl;
    logic    q_empty;
    logic    sp_zero;
    logic    wp_full;
    logic    top_null;
    logic    depth_one;
    logic    depth_max;
    logic    res_busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/graph_traversal_engine.sv =====
// top level of the graph traversal engine
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; busy stays high until the
// request's last result has been shown. An add edge request gives no result; a rejected
// request gives one result. A traversal checks the request, then scans edges in breadth-first,
// stack depth-first and recursive depth-first, taking vertices from the work list or entering
// and leaving them on the frame stack, and then shows the last result; every step waits on
// one registered read of a single-port memory.
// Results appear one per cycle at most, each for exactly one cycle with result_valid_o,
// and cannot be held off; last_o marks the final result of a request.
module graph_traversal_engine #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256,
  parameter int unsigned STACK_DEPTH  = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [gte_pkg::ACT_W-1:0]   action_i,
  input  logic [gte_pkg::VTX_W-1:0]   from_vertex_i,
  input  logic [gte_pkg::VTX_W-1:0]   to_vertex_i,
  input  logic                        cfg_we_i,
  input  logic [gte_pkg::NV_W-1:0]    cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [gte_pkg::VTX_W-1:0]   vertex_o,
  output logic [gte_pkg::STS_W-1:0]   status_o,
  output logic                        last_o
);
  import gte_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gte_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .vertex_o       (vertex_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/core/gte_dp.sv =====
// datapath: edge store, adjacency lists, visited map, work list, frames and result output
`timescale 1ns / 1ps
module gte_dp #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256,
  parameter int unsigned STACK_DEPTH  = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gte_pkg::dp_cmd_t            cmd_i,
  output gte_pkg::dp_sts_t            sts_o,
  input  logic [gte_pkg::ACT_W-1:0]   action_i,
  input  logic [gte_pkg::VTX_W-1:0]   from_vertex_i,
  input  logic [gte_pkg::VTX_W-1:0]   to_vertex_i,
  input  logic                        cfg_we_i,
  input  logic [gte_pkg::NV_W-1:0]    cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [gte_pkg::VTX_W-1:0]   vertex_o,
  output logic [gte_pkg::STS_W-1:0]   status_o,
  output logic                        last_o
);
  import gte_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0]   NULL_E = EW'(MAX_EDGES);
  localparam logic [NV_W-1:0] NV_MAX = NV_W'(MAX_VERTICES);
  localparam logic [NV_W-1:0] NV_RST = (MAX_VERTICES < 64) ? NV_W'(MAX_VERTICES) : NV_W'(64);

  // configuration
  logic [NV_W-1:0] nv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= NV_RST;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        nv_q <= NV_W'(1);
      end else if (cfg_wdata_i > NV_MAX) begin
        nv_q <= NV_MAX;
      end else begin
        nv_q <= cfg_wdata_i;
      end
    end
  end

  // captured request
  action_e          act_q;
  logic [VTX_W-1:0] from_q, to_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      act_q  <= action_e'(action_i);
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
    end
  end

  logic [VW-1:0] from_v, to_v;
  assign from_v = from_q[VW-1:0];
  assign to_v   = to_q[VW-1:0];

  // memories and their read registers
  logic [VW-1:0]   edge_tgt_mem [MAX_EDGES];
  logic [EW-1:0]   edge_nxt_mem [MAX_EDGES];
  logic [EW-1:0]   head_mem     [MAX_VERTICES];
  logic [EW-1:0]   tail_mem     [MAX_VERTICES];
  logic [VW-1:0]   wl_mem       [STACK_DEPTH];
  logic [2*EW-1:0] frame_mem    [MAX_VERTICES];

  logic [VW-1:0]   tgt_rd, wl_rd;
  logic [EW-1:0]   nxt_rd, head_rd, tail_rd;
  logic [2*EW-1:0] frame_rd;

  // control registers
  logic [EW-1:0]           cnt_q;
  logic [MAX_VERTICES-1:0] nonempty_q, visited_q, visited_d;
  logic [VW-1:0]           cur_q;
  logic [EW-1:0]           e_q, tail_q, top_cur_q, top_tail_q;
  logic [DW-1:0]           depth_q;
  logic [SW-1:0]           rd_q, wp_q;

  logic [VW-1:0] list_addr, vis_idx;
  logic [EW-1:0] edge_addr, adv;
  logic [DW-1:0] depth_m1, depth_m2;
  logic [SW-1:0] wp_m1;

  always_comb begin
    case (cmd_i.list_sel)
      VS_WL:   list_addr = wl_rd;
      VS_TGT:  list_addr = tgt_rd;
      default: list_addr = from_v;
    endcase
    case (cmd_i.vis_sel)
      VS_WL:   vis_idx = wl_rd;
      VS_TGT:  vis_idx = tgt_rd;
      default: vis_idx = from_v;
    endcase
    case (cmd_i.edge_sel)
      ES_NEXT: edge_addr = nxt_rd;
      ES_TOP:  edge_addr = top_cur_q;
      default: edge_addr = head_rd;
    endcase
  end

  assign adv      = (top_cur_q == top_tail_q) ? NULL_E : nxt_rd;
  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);
  assign wp_m1    = wp_q - SW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_rd) begin
      tgt_rd <= edge_tgt_mem[edge_addr[AW-1:0]];
      nxt_rd <= edge_nxt_mem[edge_addr[AW-1:0]];
    end
    if (cmd_i.add_wr) begin
      edge_tgt_mem[cnt_q[AW-1:0]] <= to_v;
      if (nonempty_q[from_v]) begin
        edge_nxt_mem[tail_rd[AW-1:0]] <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.list_rd) begin
      head_rd <= head_mem[list_addr];
      tail_rd <= tail_mem[list_addr];
    end
    if (cmd_i.add_wr) begin
      tail_mem[from_v] <= cnt_q;
      if (!nonempty_q[from_v]) begin
        head_mem[from_v] <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wl_pop_q) begin
      wl_rd <= wl_mem[rd_q[LW-1:0]];
    end else if (cmd_i.wl_pop_s) begin
      wl_rd <= wl_mem[wp_m1[LW-1:0]];
    end
    if (cmd_i.wl_init) begin
      wl_mem[0] <= from_v;
    end else if (cmd_i.wl_push) begin
      wl_mem[wp_q[LW-1:0]] <= tgt_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fr_pop_rd) begin
      frame_rd <= frame_mem[depth_m2[VW-1:0]];
    end
    if (cmd_i.fr_push) begin
      frame_mem[depth_m1[VW-1:0]] <= {adv, top_tail_q};
    end
  end

  always_comb begin
    visited_d = cmd_i.vis_clr ? '0 : visited_q;
    if (cmd_i.vis_set) begin
      visited_d[vis_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      nonempty_q <= '0;
      visited_q  <= '0;
    end else begin
      visited_q <= visited_d;
      if (cmd_i.add_wr) begin
        cnt_q              <= cnt_q + EW'(1);
        nonempty_q[from_v] <= 1'b1;
      end
    end
  end

  // traversal pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.list_rd) begin
      cur_q <= list_addr;
    end
    if (cmd_i.edge_rd) begin
      e_q <= edge_addr;
      if (cmd_i.edge_sel == ES_HEAD) begin
        tail_q <= tail_rd;
      end
    end
    if (cmd_i.wl_init) begin
      wp_q <= SW'(1);
      rd_q <= '0;
    end else if (cmd_i.wl_push) begin
      wp_q <= wp_q + SW'(1);
    end else if (cmd_i.wl_pop_s) begin
      wp_q <= wp_m1;
    end
    if (cmd_i.wl_pop_q) begin
      rd_q <= rd_q + SW'(1);
    end
    if (cmd_i.depth_clr) begin
      depth_q <= '0;
    end else if (cmd_i.top_load) begin
      depth_q <= depth_q + DW'(1);
    end else if (cmd_i.fr_pop) begin
      depth_q <= depth_m1;
    end
    if (cmd_i.top_load) begin
      top_cur_q  <= nonempty_q[cur_q] ? head_rd : NULL_E;
      top_tail_q <= tail_rd;
    end else if (cmd_i.fr_pop) begin
      {top_cur_q, top_tail_q} <= frame_rd;
    end else if (cmd_i.top_adv) begin
      top_cur_q <= adv;
    end
  end

  // one result held back so the final one can be marked
  logic             pend_v_q;
  logic [VTX_W-1:0] pend_vtx_q, new_vtx;
  status_e          pend_sts_q, new_sts;
  logic             res_v_q, res_last_q;
  logic [VTX_W-1:0] res_vtx_q;
  status_e          res_sts_q;

  always_comb begin
    new_sts = STS_VISIT;
    case (cmd_i.res_sel)
      RS_FROM: new_vtx = from_q;
      RS_WL:   new_vtx = VTX_W'(wl_rd);
      RS_TGT:  new_vtx = VTX_W'(tgt_rd);
      RS_REJ: begin
        new_vtx = '0;
        new_sts = STS_REJECT;
      end
      RS_OVF: begin
        new_vtx = '0;
        new_sts = STS_OVERFLOW;
      end
      default: new_vtx = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= (cmd_i.produce && pend_v_q) || cmd_i.finish;
      if (cmd_i.produce) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.produce || cmd_i.finish) begin
      res_vtx_q  <= pend_vtx_q;
      res_sts_q  <= pend_sts_q;
      res_last_q <= cmd_i.finish;
    end
    if (cmd_i.produce) begin
      pend_vtx_q <= new_vtx;
      pend_sts_q <= new_sts;
    end
  end

  assign result_valid_o = res_v_q;
  assign vertex_o       = res_vtx_q;
  assign status_o       = res_sts_q;
  assign last_o         = res_last_q;

  always_comb begin
    sts_o.act       = act_q;
    sts_o.bad_src   = {1'b0, from_q} >= nv_q;
    sts_o.bad_add   = ({1'b0, from_q} >= nv_q) || ({1'b0, to_q} >= nv_q);
    sts_o.full      = cnt_q == NULL_E;
    sts_o.nonempty  = nonempty_q[cur_q];
    sts_o.e_last    = e_q == tail_q;
    sts_o.vis_tgt   = visited_q[tgt_rd];
    sts_o.vis_wl    = visited_q[wl_rd];
    sts_o.q_empty   = rd_q == wp_q;
    sts_o.sp_zero   = wp_q == '0;
    sts_o.wp_full   = wp_q == SW'(STACK_DEPTH);
    sts_o.top_null  = top_cur_q == NULL_E;
    sts_o.depth_one = depth_q == DW'(1);
    sts_o.depth_max = depth_q == DW'(MAX_VERTICES);
    sts_o.res_busy  = res_v_q;
  end

endmodule

// ===== rtl/core/gte_ctrl.sv =====
// controller state machine sequencing edge loads and the three traversals
`timescale 1ns / 1ps
module gte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gte_pkg::dp_sts_t  sts_i,
  output gte_pkg::dp_cmd_t  cmd_o
);
  import gte_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE) || sts_i.res_busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.act == ACT_ADD) begin
          if (sts_i.bad_add || sts_i.full) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RS_REJ;
            state_d       = S_FIN;
          end else begin
            cmd_o.list_rd  = 1'b1;
            cmd_o.list_sel = VS_FROM;
            state_d        = S_ADD_WR;
          end
        end else if (sts_i.bad_src) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RS_REJ;
          state_d       = S_FIN;
        end else begin
          cmd_o.vis_clr = 1'b1;
          case (sts_i.act)
            ACT_BFS: begin
              cmd_o.vis_set = 1'b1;
              cmd_o.vis_sel = VS_FROM;
              cmd_o.wl_init = 1'b1;
              state_d       = S_B_POP;
            end
            ACT_DFS_REC: begin
              cmd_o.vis_set   = 1'b1;
              cmd_o.vis_sel   = VS_FROM;
              cmd_o.produce   = 1'b1;
              cmd_o.res_sel   = RS_FROM;
              cmd_o.list_rd   = 1'b1;
              cmd_o.list_sel  = VS_FROM;
              cmd_o.depth_clr = 1'b1;
              state_d         = S_R_LOAD;
            end
            default: begin
              cmd_o.wl_init = 1'b1;
              state_d       = S_K_POP;
            end
          endcase
        end
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_B_POP: begin
        if (sts_i.q_empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.wl_pop_q = 1'b1;
          state_d        = S_B_VTX;
        end
      end
      S_B_VTX: begin
        cmd_o.produce  = 1'b1;
        cmd_o.res_sel  = RS_WL;
        cmd_o.list_rd  = 1'b1;
        cmd_o.list_sel = VS_WL;
        state_d        = S_B_HEAD;
      end
      S_B_HEAD: begin
        if (sts_i.nonempty) begin
          cmd_o.edge_rd  = 1'b1;
          cmd_o.edge_sel = ES_HEAD;
          state_d        = S_B_EDGE;
        end else begin
          state_d = S_B_POP;
        end
      end
      S_B_EDGE: begin
        if (!sts_i.vis_tgt && !sts_i.wp_full) begin
          cmd_o.vis_set = 1'b1;
          cmd_o.vis_sel = VS_TGT;
          cmd_o.wl_push = 1'b1;
        end
        if (sts_i.e_last) begin
          state_d = S_B_POP;
        end else begin
          cmd_o.edge_rd  = 1'b1;
          cmd_o.edge_sel = ES_NEXT;
        end
      end
      S_K_POP: begin
        if (sts_i.sp_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.wl_pop_s = 1'b1;
          state_d        = S_K_VTX;
        end
      end
      S_K_VTX: begin
        if (!sts_i.vis_wl) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RS_WL;
          cmd_o.vis_set = 1'b1;
          cmd_o.vis_sel = VS_WL;
        end
        cmd_o.list_rd  = 1'b1;
        cmd_o.list_sel = VS_WL;
        state_d        = S_K_HEAD;
      end
      S_K_HEAD: begin
        if (sts_i.nonempty) begin
          cmd_o.edge_rd  = 1'b1;
          cmd_o.edge_sel = ES_HEAD;
          state_d        = S_K_EDGE;
        end else begin
          state_d = S_K_POP;
        end
      end
      S_K_EDGE: begin
        if (!sts_i.vis_tgt && sts_i.wp_full) begin
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RS_OVF;
          state_d       = S_FIN;
        end else begin
          if (!sts_i.vis_tgt) begin
            cmd_o.wl_push = 1'b1;
          end
          if (sts_i.e_last) begin
            state_d = S_K_POP;
          end else begin
            cmd_o.edge_rd  = 1'b1;
            cmd_o.edge_sel = ES_NEXT;
          end
        end
      end
      S_R_LOAD: begin
        cmd_o.top_load = 1'b1;
        state_d        = S_R_STEP;
      end
      S_R_STEP: begin
        if (sts_i.top_null) begin
          if (sts_i.depth_one) begin
            state_d = S_FIN;
          end else begin
            cmd_o.fr_pop_rd = 1'b1;
            state_d         = S_R_POP;
          end
        end else begin
          cmd_o.edge_rd  = 1'b1;
          cmd_o.edge_sel = ES_TOP;
          state_d        = S_R_EDGE;
        end
      end
      S_R_POP: begin
        cmd_o.fr_pop = 1'b1;
        state_d      = S_R_STEP;
      end
      S_R_EDGE: begin
        cmd_o.top_adv = 1'b1;
        if (!sts_i.vis_tgt && !sts_i.depth_max) begin
          cmd_o.produce  = 1'b1;
          cmd_o.res_sel  = RS_TGT;
          cmd_o.vis_set  = 1'b1;
          cmd_o.vis_sel  = VS_TGT;
          cmd_o.fr_push  = 1'b1;
          cmd_o.list_rd  = 1'b1;
          cmd_o.list_sel = VS_TGT;
          state_d        = S_R_LOAD;
        end else begin
          state_d = S_R_STEP;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/gte_checker.sv =====
// port-level checks for the graph traversal engine and their binding
`timescale 1ns / 1ps
module gte_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [gte_pkg::STS_W-1:0]   status_o,
  input logic                        last_o
);
  import gte_pkg::*;

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while not busy");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result follows the final result");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != STS_VISIT) |-> last_o)
    else $error("reject or overflow result not marked last");

endmodule

bind graph_traversal_engine gte_checker u_gte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .last_o         (last_o)
);
